// ===== rtl/ttcw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ttcw_pkg;

    localparam int ROWS_DEF = 25;
    localparam int COLS_DEF = 80;

    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    localparam logic [3:0] FG_RESET = 4'd15;
    localparam logic [3:0] BG_RESET = 4'd0;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 56;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_MOVE  = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_READ  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CFG_FG      = 2'd0,
        CFG_BG      = 2'd1,
        CFG_STREAM  = 2'd2,
        CFG_CURSOR  = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CHG_NONE   = 2'd0,
        CHG_SCROLL = 2'd1,
        CHG_CLEAR  = 2'd2
    } t_change;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_RDWAIT,
        ST_SCRL_RD,
        ST_SCRL_WR,
        ST_FILL,
        ST_PRINT,
        ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_INIT_FILL,
        OP_IDLE,
        OP_EXEC,
        OP_RD_CAPTURE,
        OP_SCRL_RD,
        OP_SCRL_WR,
        OP_FILL,
        OP_PRINT,
        OP_LOAD_OUT
    } t_op;

    typedef struct packed {
        t_kind kind;
        logic  is_nl;
        logic  is_bs;
        logic  scroll;     // item in EXEC needs a scroll first
        logic  read_ok;    // read target inside the screen
        logic  sweep_last; // sweep address at the last cell
        logic  out_free;   // output register can take a result
        logic  in_valid;
    } t_status;

endpackage
`default_nettype wire

// ===== rtl/ttcw_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ttcw_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire  ttcw_pkg::t_status i_status,
    output ttcw_pkg::t_op     o_op
);
    import ttcw_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   printable;

    assign printable = (i_status.kind == KIND_WRITE) && !i_status.is_nl && !i_status.is_bs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (i_status.sweep_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_status.in_valid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                case (i_status.kind)
                    KIND_WRITE: begin
                        if (i_status.scroll) n_state = ST_SCRL_RD;
                        else if (printable) n_state = ST_PRINT;
                        else n_state = ST_DONE;
                    end
                    KIND_CLEAR: n_state = ST_FILL;
                    KIND_READ:  n_state = i_status.read_ok ? ST_RDWAIT : ST_DONE;
                    default:    n_state = ST_DONE;
                endcase
            end
            ST_RDWAIT:  n_state = ST_DONE;
            ST_SCRL_RD: n_state = ST_SCRL_WR;
            ST_SCRL_WR: begin
                n_state = i_status.sweep_last ? ST_FILL : ST_SCRL_RD;
            end
            ST_FILL: begin
                if (i_status.sweep_last) n_state = printable ? ST_PRINT : ST_DONE;
            end
            ST_PRINT: n_state = ST_DONE;
            ST_DONE: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_INIT;
        endcase
    end

    always_comb begin
        case (r_state)
            ST_INIT:    o_op = OP_INIT_FILL;
            ST_IDLE:    o_op = OP_IDLE;
            ST_EXEC:    o_op = OP_EXEC;
            ST_RDWAIT:  o_op = OP_RD_CAPTURE;
            ST_SCRL_RD: o_op = OP_SCRL_RD;
            ST_SCRL_WR: o_op = OP_SCRL_WR;
            ST_FILL:    o_op = OP_FILL;
            ST_PRINT:   o_op = OP_PRINT;
            ST_DONE:    o_op = OP_LOAD_OUT;
            default:    o_op = OP_INIT_FILL;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/ttcw_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ttcw_dpath #(
    parameter int ROWS = ttcw_pkg::ROWS_DEF,
    parameter int COLS = ttcw_pkg::COLS_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire  ttcw_pkg::t_op                  i_op,
    output ttcw_pkg::t_status                    o_status,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire  [ttcw_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    input  wire  [1:0]                           s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    output logic [ttcw_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    input  wire                                  i_cfg_we,
    input  wire  [1:0]                           i_cfg_idx,
    input  wire  [3:0]                           i_cfg_data
);
    import ttcw_pkg::*;

    localparam int CELLS = ROWS * COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS + 1);
    localparam int CW    = $clog2(COLS + 1);

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
                                                input logic [CW-1:0] col);
        logic [31:0] lin;
        lin = 32'(row) * 32'(COLS) + 32'(col);
        return lin[AW-1:0];
    endfunction

    // configuration
    logic [3:0] r_fg, r_bg;
    logic       r_stream, r_curvis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg     <= FG_RESET;
            r_bg     <= BG_RESET;
            r_stream <= 1'b1;
            r_curvis <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_FG:     r_fg     <= i_cfg_data;
                CFG_BG:     r_bg     <= i_cfg_data;
                CFG_STREAM: r_stream <= i_cfg_data[0];
                CFG_CURSOR: r_curvis <= i_cfg_data[0];
                default:    ;
            endcase
        end
    end

    // cell store: character and color halves written separately
    logic [7:0] mem_ch [CELLS];
    logic [7:0] mem_co [CELLS];
    logic [7:0] r_rd_ch, r_rd_co;
    logic [AW-1:0] rd_addr, wr_addr;
    logic       we_ch, we_co;
    logic [7:0] wd_ch, wd_co;

    always_ff @(posedge i_clk) begin
        if (we_ch) mem_ch[wr_addr] <= wd_ch;
        if (we_co) mem_co[wr_addr] <= wd_co;
        r_rd_ch <= mem_ch[rd_addr];
        r_rd_co <= mem_co[rd_addr];
    end

    // latched item
    t_kind       r_kind;
    logic [7:0]  r_char;
    logic [4:0]  r_trow;
    logic [6:0]  r_tcol;

    // cursor and sweep
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [AW-1:0] r_addr, n_addr;

    // pending result cell
    logic          r_cv, n_cv;
    logic [4:0]    r_crow, n_crow;
    logic [6:0]    r_ccol, n_ccol;
    logic [7:0]    r_cch, n_cch;
    logic [3:0]    r_cfg, n_cfg;
    logic [3:0]    r_cbg, n_cbg;
    logic          r_show, n_show;
    t_change       r_chg, n_chg;

    logic          r_ovalid;
    logic [OUT_DATA_W-1:0] r_odata;

    // decode
    logic          is_nl, is_bs, rd_ok, mv_row_ok, mv_col_ok;
    logic [RW-1:0] wr_row, bs_row;
    logic [CW-1:0] wr_col, bs_col, col_clip;
    logic          bs_moved, pr_scroll, nl_scroll;
    logic [31:0]   lin32;

    assign is_nl     = (r_char == CH_NEWLINE);
    assign is_bs     = (r_char == CH_BACKSPACE);
    assign rd_ok     = (32'(r_trow) < ROWS) && (32'(r_tcol) < COLS);
    assign mv_row_ok = (32'(r_trow) < ROWS);
    assign mv_col_ok = (32'(r_tcol) <= COLS);
    assign wr_row    = (32'(r_col) >= COLS) ? r_row + RW'(1) : r_row;
    assign wr_col    = (32'(r_col) >= COLS) ? '0 : r_col;
    assign pr_scroll = (32'(wr_row) >= ROWS);
    assign nl_scroll = !(32'(r_row) + 32'd1 < ROWS);
    assign col_clip  = (32'(r_col) > COLS) ? CW'(COLS) : r_col;
    assign bs_moved  = (r_col != '0) || (r_row != '0);
    assign bs_row    = (r_col != '0) ? r_row : r_row - RW'(1);
    assign bs_col    = (r_col != '0) ? col_clip - CW'(1) : CW'(COLS - 1);
    assign lin32     = 32'(r_row) * 32'(COLS) + 32'(r_col);

    always_comb begin
        o_status.kind       = r_kind;
        o_status.is_nl      = is_nl;
        o_status.is_bs      = is_bs;
        o_status.scroll     = (r_kind == KIND_WRITE) &&
                              (is_nl ? nl_scroll : (!is_bs && pr_scroll));
        o_status.read_ok    = rd_ok;
        o_status.sweep_last = (r_addr == AW'(CELLS - 1));
        o_status.out_free   = !r_ovalid || m_axis_tready;
        o_status.in_valid   = s_axis_tvalid;
    end

    assign s_axis_tready = (i_op == OP_IDLE);

    // memory ports
    always_comb begin
        rd_addr = (i_op == OP_SCRL_RD) ? r_addr : cell_addr(RW'(r_trow), CW'(r_tcol));
        we_ch   = 1'b0;
        we_co   = 1'b0;
        wr_addr = r_addr;
        wd_ch   = CH_SPACE;
        wd_co   = {r_bg, r_fg};
        case (i_op)
            OP_INIT_FILL: begin
                we_ch = 1'b1;
                we_co = 1'b1;
                wd_co = {BG_RESET, FG_RESET};
            end
            OP_FILL: begin
                we_ch = 1'b1;
                we_co = 1'b1;
            end
            OP_SCRL_WR: begin
                we_ch   = 1'b1;
                we_co   = 1'b1;
                wr_addr = r_addr - AW'(COLS);
                wd_ch   = r_rd_ch;
                wd_co   = r_rd_co;
            end
            OP_EXEC: begin
                we_ch   = (r_kind == KIND_WRITE) && !is_nl && is_bs && bs_moved;
                wr_addr = cell_addr(bs_row, bs_col);
            end
            OP_PRINT: begin
                we_ch   = 1'b1;
                we_co   = 1'b1;
                wr_addr = cell_addr(r_row, r_col);
                wd_ch   = r_char;
            end
            default: ;
        endcase
    end

    // cursor, sweep and result cell
    always_comb begin
        n_row  = r_row;
        n_col  = r_col;
        n_addr = r_addr;
        n_cv   = r_cv;
        n_crow = r_crow;
        n_ccol = r_ccol;
        n_cch  = r_cch;
        n_cfg  = r_cfg;
        n_cbg  = r_cbg;
        n_show = r_show;
        n_chg  = r_chg;
        case (i_op)
            OP_INIT_FILL, OP_FILL, OP_SCRL_RD: begin
                if (i_op != OP_SCRL_RD) n_addr = r_addr + AW'(1);
            end
            OP_SCRL_WR: begin
                n_addr = (r_addr == AW'(CELLS - 1)) ? AW'(CELLS - COLS) : r_addr + AW'(1);
            end
            OP_IDLE: begin
                n_cv   = 1'b0;
                n_crow = '0;
                n_ccol = '0;
                n_cch  = '0;
                n_cfg  = '0;
                n_cbg  = '0;
                n_show = 1'b0;
                n_chg  = CHG_NONE;
            end
            OP_EXEC: begin
                case (r_kind)
                    KIND_WRITE: begin
                        if (is_nl) begin
                            if (nl_scroll) begin
                                n_chg  = CHG_SCROLL;
                                n_row  = RW'(ROWS - 1);
                                n_col  = '0;
                                n_addr = AW'(COLS);
                            end else begin
                                n_row = r_row + RW'(1);
                                n_col = '0;
                            end
                        end else if (is_bs) begin
                            if (bs_moved) begin
                                n_row  = bs_row;
                                n_col  = bs_col;
                                n_cv   = 1'b1;
                                n_crow = 5'(bs_row);
                                n_ccol = 7'(bs_col);
                                n_cch  = CH_SPACE;
                                n_cfg  = r_fg;
                                n_cbg  = r_bg;
                                n_show = r_stream;
                            end
                        end else if (pr_scroll) begin
                            n_chg  = CHG_SCROLL;
                            n_row  = RW'(ROWS - 1);
                            n_col  = '0;
                            n_addr = AW'(COLS);
                        end else begin
                            n_row = wr_row;
                            n_col = wr_col;
                        end
                    end
                    KIND_MOVE: begin
                        if (mv_row_ok) n_row = RW'(r_trow);
                        if (mv_col_ok) n_col = CW'(r_tcol);
                    end
                    KIND_CLEAR: begin
                        n_chg  = CHG_CLEAR;
                        n_row  = '0;
                        n_col  = '0;
                        n_addr = '0;
                    end
                    default: begin
                        if (rd_ok) begin
                            n_cv   = 1'b1;
                            n_crow = r_trow;
                            n_ccol = r_tcol;
                        end
                    end
                endcase
            end
            OP_RD_CAPTURE: begin
                n_cch = r_rd_ch;
                n_cfg = r_rd_co[3:0];
                n_cbg = r_rd_co[7:4];
            end
            OP_PRINT: begin
                n_cv   = 1'b1;
                n_crow = 5'(r_row);
                n_ccol = 7'(r_col);
                n_cch  = r_char;
                n_cfg  = r_fg;
                n_cbg  = r_bg;
                n_show = r_stream;
                n_col  = r_col + CW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row    <= '0;
            r_col    <= '0;
            r_addr   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_row  <= n_row;
            r_col  <= n_col;
            r_addr <= n_addr;
            if (i_op == OP_LOAD_OUT && o_status.out_free) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cv   <= n_cv;
        r_crow <= n_crow;
        r_ccol <= n_ccol;
        r_cch  <= n_cch;
        r_cfg  <= n_cfg;
        r_cbg  <= n_cbg;
        r_show <= n_show;
        r_chg  <= n_chg;
        if (i_op == OP_IDLE && s_axis_tvalid) begin
            r_kind <= t_kind'(s_axis_tuser);
            r_char <= s_axis_tdata[7:0];
            r_trow <= s_axis_tdata[12:8];
            r_tcol <= s_axis_tdata[19:13];
        end
        if (i_op == OP_LOAD_OUT && o_status.out_free) begin
            r_odata <= {r_curvis, lin32[10:0], 7'(r_col), 5'(r_row), r_chg, r_show,
                        r_cbg, r_cfg, r_cch, r_ccol, r_crow, r_cv};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

endmodule
`default_nettype wire

// ===== rtl/text_terminal_cell_writer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Text-mode terminal cell writer: a ROWS x COLS character-cell store plus a
// cursor. Each input transaction (kind on s_axis_tuser) writes a character,
// moves the cursor, clears the screen or reads a cell, and yields exactly one
// output transaction with the touched cell, any screen-wide change and the
// cursor. After reset the store is blanked by one pass over all ROWS*COLS
// cells (2000 by default) before s_axis_tready rises; configuration writes
// are taken during that pass. Each item is first executed; a printed
// character is then written or an in-range read captured, and the result
// loads into the output register once that is free. A scroll moves each
// cell one row up (read, then write) and then fills the bottom row; a clear
// fills ROWS*COLS cells, one per cycle. The next item is accepted while a
// finished result waits in the output register.
module text_terminal_cell_writer #(
    parameter int ROWS = ttcw_pkg::ROWS_DEF,
    parameter int COLS = ttcw_pkg::COLS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // char_code[7:0], dest_row[12:8], dest_col[19:13], zero pad [23:20]
    input  wire  [ttcw_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // kind[1:0]
    input  wire  [1:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // cell_valid[0], cell_row[5:1], cell_col[12:6], cell_char[20:13],
    // cell_fg[24:21], cell_bg[28:25], show_now[29], screen_change[31:30],
    // cur_row[36:32], cur_col[43:37], cursor_linear[54:44], cursor_shown[55]
    output logic [ttcw_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // 0 text_fg, 1 text_bg, 2 stream_mode, 3 cursor_visible
    input  wire                               i_cfg_we,
    input  wire  [1:0]                        i_cfg_idx,
    input  wire  [3:0]                        i_cfg_data
);
    import ttcw_pkg::*;

    t_op     op;
    t_status status;

    // sequencing: init pass, per-item steps, scroll and fill sweeps
    ttcw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_op     (op)
    );

    // cell store, cursor, config and output register
    ttcw_dpath #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (op),
        .o_status      (status),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

endmodule
`default_nettype wire
